// ===== rtl/blink_detector_unit_assert.svh =====
// assertion helpers shared by the blink detector modules
// each macro expects clk and rst_n in scope
`ifndef BLINK_DETECTOR_UNIT_ASSERT_SVH
`define BLINK_DETECTOR_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define BDU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BDU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/blkdet_pkg.sv =====
`default_nettype none

package blkdet_pkg;

  // configuration register widths
  localparam int PERIOD_BITS   = 32;
  localparam int FRAC_BITS     = 8;
  localparam int LOOKBACK_BITS = 16;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PERIOD    = 2'd0;
  localparam cfg_idx_t CFG_TOL_FRAC  = 2'd1;
  localparam cfg_idx_t CFG_LOOKBACK  = 2'd2;

  // register reset values
  localparam logic [PERIOD_BITS-1:0]   PERIOD_RST   = 32'd1000;
  localparam logic [FRAC_BITS-1:0]     TOL_FRAC_RST = 8'd25;
  localparam logic [LOOKBACK_BITS-1:0] LOOKBACK_RST = 16'd4;

  // tolerance is a fraction in 255ths
  localparam int                 TOL_DIV_BITS = 9;
  localparam logic [TOL_DIV_BITS-1:0] TOL_DIV  = 9'd255;

endpackage

`default_nettype wire

// ===== rtl/blkdet_if.sv =====
`default_nettype none

// sample request channel
interface blkdet_in_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 level;
  logic [TIME_BITS-1:0] time_ms;

  modport source (output valid, level, time_ms, input ready);
  modport sink   (input valid, level, time_ms, output ready);
endinterface

// result channel
interface blkdet_out_if;
  logic valid;
  logic ready;
  logic blinking;

  modport source (output valid, blinking, input ready);
  modport sink   (input valid, blinking, output ready);
endinterface

// register write channel
interface blkdet_cfg_if
  import blkdet_pkg::*;
;
  logic                     valid;
  logic                     ready;
  cfg_idx_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/blkdet_bounds.sv =====
`default_nettype none

module blkdet_bounds
  import blkdet_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  blkdet_cfg_if.sink          cfg_if,
  output logic [TIME_BITS-1:0]     lo,
  output logic [TIME_BITS-1:0]     hi,
  output logic [LOOKBACK_BITS-1:0] lookback,
  output logic                     bounds_ok
);

  `include "blink_detector_unit_assert.svh"

  localparam int PROD_BITS  = TIME_BITS + FRAC_BITS;
  localparam int DIGIT_BITS = TOL_DIV_BITS - 1;

  typedef enum logic [3:0] {
    ST_MUL = 4'b0001,
    ST_DIV = 4'b0010,
    ST_FIN = 4'b0100,
    ST_RDY = 4'b1000
  } bnd_state_t;

  bnd_state_t st_r, st_nxt;

  logic [PERIOD_BITS-1:0]   period_r;
  logic [FRAC_BITS-1:0]     frac_r;
  logic [LOOKBACK_BITS-1:0] lookback_r;

  logic [TIME_BITS-1:0]     half_r;
  logic [PROD_BITS-1:0]     prod_r, prod_nxt;
  logic [TIME_BITS-1:0]     quot_r, quot_nxt;
  logic [TIME_BITS-1:0]     lo_r, hi_r;

  logic                              cfg_wr;
  logic [TIME_BITS-1:0]              half;
  logic [PROD_BITS-DIGIT_BITS-1:0]   prod_hi;
  logic [DIGIT_BITS-1:0]             prod_lo;
  logic                              prod_small;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;

  // period is taken modulo the timestamp range before halving
  assign half   = TIME_BITS'(period_r) >> 1;

  // x = 256*a + b gives x/255 = a + (a+b)/255, one fold a cycle until below 256
  assign prod_hi    = prod_r[PROD_BITS-1:DIGIT_BITS];
  assign prod_lo    = prod_r[DIGIT_BITS-1:0];
  assign prod_small = (prod_hi == '0);

  always_comb begin
    st_nxt   = st_r;
    prod_nxt = prod_r;
    quot_nxt = quot_r;
    unique case (st_r)
      ST_MUL: begin
        prod_nxt = PROD_BITS'(half) * PROD_BITS'(frac_r);
        quot_nxt = '0;
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (!prod_small) begin
          quot_nxt = quot_r + TIME_BITS'(prod_hi);
          prod_nxt = PROD_BITS'(prod_hi) + PROD_BITS'(prod_lo);
        end else begin
          // remainder of exactly 255 still owes one
          if ({1'b0, prod_lo} >= TOL_DIV) begin
            quot_nxt = quot_r + 1'b1;
          end
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        st_nxt = ST_RDY;
      end
      ST_RDY: begin
        st_nxt = ST_RDY;
      end
      default: begin
        st_nxt = ST_MUL;
      end
    endcase
    // any register write restarts the bound computation
    if (cfg_wr) begin
      st_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_MUL;
      period_r   <= PERIOD_RST;
      frac_r     <= TOL_FRAC_RST;
      lookback_r <= LOOKBACK_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr) begin
        if (cfg_if.index == CFG_PERIOD) begin
          period_r <= cfg_if.data;
        end
        if (cfg_if.index == CFG_TOL_FRAC) begin
          frac_r <= cfg_if.data[FRAC_BITS-1:0];
        end
        if (cfg_if.index == CFG_LOOKBACK) begin
          lookback_r <= cfg_if.data[LOOKBACK_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    quot_r <= quot_nxt;
    if (st_r == ST_MUL) begin
      half_r <= half;
    end
    if (st_r == ST_FIN) begin
      lo_r <= half_r - quot_r;
      hi_r <= half_r + quot_r;
    end
  end

  assign lo        = lo_r;
  assign hi        = hi_r;
  assign lookback  = lookback_r;
  assign bounds_ok = (st_r == ST_RDY);

  `BDU_ASSERT_NEXT(a_wr_restarts, cfg_wr, !bounds_ok, "bounds still valid after write")
  `BDU_ASSERT_IMPLIES(a_window_order, bounds_ok, lo_r <= hi_r, "window low above high")
  `BDU_ASSERT_NEXT(a_div_ends, (st_r == ST_DIV) && prod_small && !cfg_wr,
    st_r == ST_FIN, "divider did not finish")

endmodule

`default_nettype wire

// ===== rtl/blkdet_core.sv =====
`default_nettype none

module blkdet_core
  import blkdet_pkg::*;
#(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  blkdet_in_if.sink                 in_if,
  blkdet_out_if.source              out_if,
  input  wire logic [TIME_BITS-1:0]     lo,
  input  wire logic [TIME_BITS-1:0]     hi,
  input  wire logic [LOOKBACK_BITS-1:0] lookback,
  input  wire logic                     bounds_ok
);

  `include "blink_detector_unit_assert.svh"

  localparam int CMP_BITS = COUNT_BITS + LOOKBACK_BITS;

  // input register
  logic                 s1_valid_r;
  logic                 s1_level_r;
  logic [TIME_BITS-1:0] s1_time_r;

  // detector state
  logic                  first_r, first_nxt;
  logic                  edge_seen_r, edge_seen_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  last_edge_r, last_edge_nxt;
  logic                  last_level_r, last_level_nxt;
  logic                  flag_r, flag_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_blink_r;

  logic                  advance;
  logic                  in_acc;
  logic [TIME_BITS-1:0]  dur;
  logic                  in_win;
  logic                  late;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = bounds_ok && (!s1_valid_r || advance);
  assign in_acc      = in_if.valid && in_if.ready;

  // wrapping edge-to-edge time
  assign dur     = s1_time_r - last_edge_r;
  assign in_win  = (dur >= lo) && (dur <= hi);
  assign late    = (dur > hi);
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    first_nxt      = first_r;
    edge_seen_nxt  = edge_seen_r;
    cnt_nxt        = cnt_r;
    last_edge_nxt  = last_edge_r;
    last_level_nxt = last_level_r;
    flag_nxt       = flag_r;
    priority if (first_r) begin
      last_level_nxt = s1_level_r;
      first_nxt      = 1'b0;
    end else if (s1_level_r != last_level_r) begin
      if (edge_seen_r) begin
        if (in_win) begin
          cnt_nxt = cnt_inc;
          if (CMP_BITS'(cnt_inc) >= CMP_BITS'(lookback)) begin
            flag_nxt = 1'b1;
          end
        end else begin
          cnt_nxt  = '0;
          flag_nxt = 1'b0;
        end
      end
      last_edge_nxt  = s1_time_r;
      edge_seen_nxt  = 1'b1;
      last_level_nxt = s1_level_r;
    end else if (edge_seen_r && late) begin
      // edge went stale
      cnt_nxt       = '0;
      flag_nxt      = 1'b0;
      edge_seen_nxt = 1'b0;
    end else begin
      flag_nxt = flag_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      first_r      <= 1'b1;
      edge_seen_r  <= 1'b0;
      cnt_r        <= '0;
      last_edge_r  <= '0;
      last_level_r <= 1'b0;
      flag_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        first_r      <= first_nxt;
        edge_seen_r  <= edge_seen_nxt;
        cnt_r        <= cnt_nxt;
        last_edge_r  <= last_edge_nxt;
        last_level_r <= last_level_nxt;
        flag_r       <= flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_level_r <= in_if.level;
      s1_time_r  <= in_if.time_ms;
    end
    if (advance) begin
      out_blink_r <= flag_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.blinking = out_blink_r;

  `BDU_ASSERT_IMPLIES(a_flag_needs_edge, flag_r, edge_seen_r, "blinking without an edge")
  `BDU_ASSERT_IMPLIES(a_first_no_edge, first_r, !edge_seen_r, "edge before first sample")
  `BDU_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "processed sample lost")

endmodule

`default_nettype wire

// ===== rtl/blink_detector_unit.sv =====
// Blink detector: each request carries one binary level sample and its free-running
// millisecond timestamp, and produces one result, the blinking flag after that sample.
// Level changes are timed edge to edge (wrapping subtraction) and compared against the
// window half-period +/- tolerance, where half = expected_period_ms/2 and tolerance =
// half*tolerance_fraction/255; lookback_count in-window half cycles in a row set the
// flag, an out-of-window edge or a stale edge clears it. A sample passes from acceptance
// to result through the input register, then the result register, and one new sample
// is taken every cycle while the bounds are ready and the result side does not stall.
// The window bounds come from a shift-and-add divide by 255 that folds the product one
// byte a cycle: after reset and after every register write the block takes no samples
// while the bounds are rebuilt; the register port is always ready.
`default_nettype none

module blink_detector_unit
  import blkdet_pkg::*;
#(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  blkdet_in_if.sink     in_if,
  blkdet_out_if.source  out_if,
  blkdet_cfg_if.sink    cfg_if
);

  // window bounds shared by the two halves
  logic [TIME_BITS-1:0]     lo;
  logic [TIME_BITS-1:0]     hi;
  logic [LOOKBACK_BITS-1:0] lookback;
  logic                     bounds_ok;

  // config registers and the tolerance divider
  blkdet_bounds #(
    .TIME_BITS (TIME_BITS)
  ) u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_if    (cfg_if),
    .lo        (lo),
    .hi        (hi),
    .lookback  (lookback),
    .bounds_ok (bounds_ok)
  );

  // sample pipeline: input register, edge timing, result register
  blkdet_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .lo        (lo),
    .hi        (hi),
    .lookback  (lookback),
    .bounds_ok (bounds_ok)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import blkdet_pkg::*;
;

  // index with no register behind it, writes to it must be dropped
  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  // half cycle counter ceiling at the default counter width
  localparam logic [15:0] HALF_CYCLE_MAX = 16'hFFFF;
  localparam int PHASE_SAMPLES = 104;

  // predicts the blinking flag from accepted sample requests and checks results
  class blink_scoreboard;
    logic [PERIOD_BITS-1:0]   period_reg;
    logic [FRAC_BITS-1:0]     tol_frac_reg;
    logic [LOOKBACK_BITS-1:0] lookback_reg;
    bit          awaiting_first;
    bit          edge_seen;
    logic [15:0] half_cycles;
    logic [31:0] last_edge_ms;
    logic        last_level;
    logic        blink_flag;
    logic        expected_blink_q[$];
    int          errors;

    function new();
      period_reg     = PERIOD_RST;
      tol_frac_reg   = TOL_FRAC_RST;
      lookback_reg   = LOOKBACK_RST;
      awaiting_first = 1'b1;
      edge_seen      = 1'b0;
      half_cycles    = '0;
      last_edge_ms   = '0;
      last_level     = 1'b0;
      blink_flag     = 1'b0;
      errors         = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_PERIOD:   period_reg   = data;
        CFG_TOL_FRAC: tol_frac_reg = data[FRAC_BITS-1:0];
        CFG_LOOKBACK: lookback_reg = data[LOOKBACK_BITS-1:0];
        default: ;
      endcase
    endfunction

    // half +/- tolerance, tolerance product kept exact in 64 bits
    function void window(output logic [63:0] lo, output logic [63:0] hi);
      logic [63:0] half;
      logic [63:0] tol;
      half = {32'b0, period_reg} >> 1;
      tol  = (half * 64'(tol_frac_reg)) / 64'(TOL_DIV);
      lo   = half - tol;
      hi   = half + tol;
    endfunction

    function void note_sample(logic lvl, logic [31:0] t);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [31:0] dur;
      if (awaiting_first) begin
        // first sample only records the level
        last_level     = lvl;
        awaiting_first = 1'b0;
        expected_blink_q.push_back(blink_flag);
        return;
      end
      window(lo, hi);
      dur = t - last_edge_ms;
      if (lvl != last_level) begin
        if (edge_seen) begin
          if (64'(dur) >= lo && 64'(dur) <= hi) begin
            if (half_cycles != HALF_CYCLE_MAX) half_cycles++;
            if (half_cycles >= lookback_reg) blink_flag = 1'b1;
          end else begin
            half_cycles = '0;
            blink_flag  = 1'b0;
          end
        end
        last_edge_ms = t;
        edge_seen    = 1'b1;
        last_level   = lvl;
      end else if (edge_seen && 64'(dur) > hi) begin
        half_cycles = '0;
        blink_flag  = 1'b0;
        edge_seen   = 1'b0;
      end
      expected_blink_q.push_back(blink_flag);
    endfunction

    function void check_result(logic blinking);
      logic want;
      if (expected_blink_q.size() == 0) begin
        $error("blinking result with no sample outstanding: actual %0b", blinking);
        errors++;
        return;
      end
      want = expected_blink_q.pop_front();
      if (blinking !== want) begin
        $error("blinking mismatch: expected %0b, actual %0b", want, blinking);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blink_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  blkdet_in_if #(.TIME_BITS(32)) in_ch ();
  blkdet_out_if                  out_ch ();
  blkdet_cfg_if                  cfg_ch ();

  blink_detector_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  blink_scoreboard sb;

  // sample generator state: level and time of the last level change sent
  logic        gen_level = 1'b0;
  logic [31:0] gen_edge  = '0;
  // when set, the side runs with no gaps
  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;

  always #2 clk = ~clk;

  // one sample request; valid stays high afterwards so back-to-back requests
  // never lower and raise it in the same step
  task automatic send_sample(input logic lvl, input logic [31:0] t);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.level   <= lvl;
    in_ch.time_ms <= t;
    do @(posedge clk);
    while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    sb.note_sample(lvl, t);
    // track the last level change for the generator
    if (lvl != gen_level) gen_edge = t;
    gen_level = lvl;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // writes all three registers back to back, with an optional write to the
  // dead index thrown in; only called with the block drained
  task automatic program_regs(input logic [31:0] period, input logic [7:0] frac,
                              input logic [15:0] lookback, input bit poke_unused);
    cfg_idx_t    idx_q[$];
    logic [31:0] data_q[$];
    idx_q.push_back(CFG_PERIOD);   data_q.push_back(period);
    idx_q.push_back(CFG_TOL_FRAC); data_q.push_back({24'b0, frac});
    idx_q.push_back(CFG_LOOKBACK); data_q.push_back({16'b0, lookback});
    if (poke_unused) begin
      idx_q.insert($urandom_range(0, 3), CFG_UNUSED);
      data_q.insert(0, 32'b0);
      // keep data aligned with the dead index
      foreach (idx_q[i]) begin
        case (idx_q[i])
          CFG_PERIOD:   data_q[i] = period;
          CFG_TOL_FRAC: data_q[i] = {24'b0, frac};
          CFG_LOOKBACK: data_q[i] = {16'b0, lookback};
          default:      data_q[i] = $urandom;
        endcase
      end
    end
    foreach (idx_q[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx_q[i];
      cfg_ch.data  <= data_q[i];
      do @(posedge clk);
      while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
      sb.write_reg(idx_q[i], data_q[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed blink edges with random spacing inside the window,
  // the rest steady samples, near misses, stale gaps and noise
  task automatic random_sample();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] lo32;
    logic [31:0] hi32;
    logic [31:0] t;
    logic        lvl;
    int          pick;
    sb.window(lo, hi);
    lo32 = lo[31:0];
    hi32 = hi[31:0];
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      lvl = ~gen_level;
      case ($urandom_range(0, 3))
        0:       t = gen_edge + lo32;
        1:       t = gen_edge + hi32;
        default: t = gen_edge + $urandom_range(hi32, lo32);
      endcase
    end else if (pick < 77) begin
      // steady level, not yet past the window
      lvl = gen_level;
      t   = gen_edge + $urandom_range(hi32, 0);
    end else if (pick < 85) begin
      // edge just outside the window on either side
      lvl = ~gen_level;
      t   = gen_edge + (($urandom_range(0, 1) == 1) ? lo32 - 32'd1 : hi32 + 32'd1);
    end else if (pick < 92) begin
      // steady level past the window, goes stale
      lvl = gen_level;
      t   = gen_edge + hi32 + 32'd1 + $urandom_range(0, 50);
    end else begin
      lvl = 1'($urandom_range(0, 1));
      t   = $urandom;
    end
    send_sample(lvl, t);
  endtask

  // result side: random stall per result, ready held when no stall is drawn
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk);
    while (rst_n !== 1'b1);
    forever begin
      stall = receiver_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      sb.check_result(out_ch.blinking);
    end
  end

  // hard stop well past the slowest passing run
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.level   <= 1'b0;
    in_ch.time_ms <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_PERIOD;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: half 500, tolerance 49, window 451..549, lookback 4
    send_sample(1'b1, 32'd0);          // first sample just records the level
    send_sample(1'b0, 32'd100);        // first edge only records its time
    send_sample(1'b1, 32'd551);        // lower window bound
    send_sample(1'b0, 32'd1100);       // upper window bound
    send_sample(1'b1, 32'd1600);
    send_sample(1'b0, 32'd2100);       // fourth good half cycle sets blinking
    send_sample(1'b0, 32'd2649);       // steady, exactly at the upper bound
    send_sample(1'b1, 32'd2550);       // one short of the window, clears
    send_sample(1'b0, 32'd3050);
    send_sample(1'b0, 32'd3600);       // steady past the window, goes stale
    send_sample(1'b1, 32'hFFFF_FF00);  // edge after stale only records
    send_sample(1'b0, 32'h0000_00F4);  // wrapping edge-to-edge time
    send_sample(1'b0, 32'hFFFF_FFFF);
    wait_for_results();

    // zero period: only same-time edges are in window, lookback zero
    program_regs(32'd0, 8'd0, 16'd0, 1'b1);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd5);          // in window, blinking at once
    send_sample(1'b1, 32'd6);          // out of window
    wait_for_results();

    // widest window: 0 .. 2^32-2
    program_regs(32'hFFFF_FFFF, 8'd255, 16'd1, 1'b0);
    send_sample(1'b0, 32'd7);
    send_sample(1'b1, 32'd5);          // wraps to 2^32-2, still in window
    send_sample(1'b1, 32'd4);          // steady, 2^32-1 is stale
    wait_for_results();

    // random phases, one register setting each
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(32'd1000, 8'd25, 16'd4, 1'b0);
        1: program_regs(32'd0, 8'd255, 16'($urandom_range(0, 2)), 1'b1);
        2: program_regs(32'hFFFF_FFFF, 8'd255, 16'd2, 1'b0);
        3: program_regs(32'hFFFF_FFFF, 8'd0, 16'd3, 1'b1);
        4: program_regs($urandom_range(2, 64), 8'($urandom),
                        16'($urandom_range(0, 5)), 1'b0);
        5: program_regs($urandom_range(100, 5000), 8'($urandom),
                        16'($urandom_range(1, 6)), 1'b1);
        6: program_regs($urandom, 8'($urandom), 16'($urandom_range(0, 65535)), 1'b1);
        default: program_regs($urandom_range(0, 300), 8'd128,
                              16'($urandom_range(0, 4)), 1'b0);
      endcase
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // stretches with and without gaps on either side
        if (n % 25 == 0) begin
          sender_quiet   = ($urandom_range(0, 3) == 0);
          receiver_quiet = ($urandom_range(0, 3) == 0);
        end
        random_sample();
        // occasionally hold off until the pipe is empty
        if ($urandom_range(0, 49) == 0) wait_for_results();
      end
      wait_for_results();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
